// ===== rtl/bal_pkg.sv =====
// Shared types, codes and layout helpers for the buddy allocator.
`default_nettype none

package bal_pkg;

	// Transaction payloads.
	typedef struct packed {
		logic        op;
		logic [7:0]  process_id;
		logic [15:0] request_size;
	} bal_req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] echo_process_id;
		logic [9:0] start_address;
		logic [9:0] end_address;
	} bal_rsp_t;

	// Operation codes.
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_ALLOCATED = 3'd0,
		ST_FREED     = 3'd1,
		ST_FULL      = 3'd2,
		ST_BAD_SIZE  = 3'd3,
		ST_UNKNOWN   = 3'd4,
		ST_HELD      = 3'd5
	} bal_status_t;

	// Free-mark memory word layout.
	localparam int WORD_W  = 32;
	localparam int WORD_LW = 5;
	localparam int ADDR_W  = 10;
	localparam int SIZE_W  = 16;

	// Number of words holding the marks of one order.
	function automatic int order_words(int top, int k);
		int n;
		n = 1 << (top - k);
		return ((n >> WORD_LW) == 0) ? 1 : (n >> WORD_LW);
	endfunction

	// First word of one order; orders are stacked from order zero upward.
	function automatic int order_wbase(int top, int k);
		int sum;
		sum = 0;
		for (int m = 0; m < k; m++) begin
			sum = sum + order_words(top, m);
		end
		return sum;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/bal_marks.sv =====
// Free-mark memory: one bit per block of every order, packed into words.
`default_nettype none

module bal_marks import bal_pkg::*; #(
	parameter int NW  = 68,
	parameter int MAW = 7
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              rd_en,
	input  wire logic              wr_en,
	input  wire logic [MAW-1:0]    addr,
	input  wire logic [WORD_W-1:0] wdata,
	output logic      [WORD_W-1:0] rdata,
	output logic      [NW-1:0]     flags
);

	localparam logic [NW-1:0] TOP_MASK = NW'(1) << (NW - 1);

	logic [WORD_W-1:0] mem [NW];
	logic [WORD_W-1:0] rdata_s1;
	logic              rd_valid_s1;
	logic              rd_top_s1;
	logic [NW-1:0]     valid_q;
	logic [NW-1:0]     nz_q;

	// Storage array with registered read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= wdata;
		end
		if (rd_en) begin
			rdata_s1 <= mem[addr];
		end
	end

	// A word never written reads as its reset pattern: only the top block free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			nz_q        <= '0;
			rd_valid_s1 <= 1'b0;
			rd_top_s1   <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[addr] <= 1'b1;
				nz_q[addr]    <= |wdata;
			end
			if (rd_en) begin
				rd_valid_s1 <= valid_q[addr];
				rd_top_s1   <= (32'(addr) == NW - 1);
			end
		end
	end

	assign rdata = rd_valid_s1 ? rdata_s1 : (rd_top_s1 ? WORD_W'(1) : '0);

	// Per-word summary of any free block, used by the search.
	assign flags = (valid_q & nz_q) | (~valid_q & TOP_MASK);

endmodule

`default_nettype wire

// ===== rtl/bal_owner.sv =====
// Owner table: valid bit per process and the block it holds.
`default_nettype none

module bal_owner import bal_pkg::*; #(
	parameter int PROCESSES = 256,
	parameter int PW        = 8,
	parameter int IXW       = 10,
	parameter int OW        = 4
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic [PW-1:0]  vidx,
	output logic                valid,
	input  wire logic           rd_en,
	input  wire logic [PW-1:0]  rd_idx,
	output logic      [IXW-1:0] rd_start,
	output logic      [OW-1:0]  rd_order,
	input  wire logic           wr_en,
	input  wire logic [PW-1:0]  wr_idx,
	input  wire logic [IXW-1:0] wr_start,
	input  wire logic [OW-1:0]  wr_order,
	input  wire logic           clr_en
);

	logic [IXW+OW-1:0]    mem [PROCESSES];
	logic [IXW+OW-1:0]    rdata_s1;
	logic [PROCESSES-1:0] valid_q;

	// Block start and order per process.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= {wr_start, wr_order};
		end
		if (rd_en) begin
			rdata_s1 <= mem[rd_idx];
		end
	end

	assign rd_start = rdata_s1[IXW+OW-1:OW];
	assign rd_order = rdata_s1[OW-1:0];

	// Valid bits; a free clears the entry addressed for writing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_idx] <= 1'b1;
		end else if (clr_en) begin
			valid_q[wr_idx] <= 1'b0;
		end
	end

	assign valid = valid_q[vidx];

endmodule

`default_nettype wire

// ===== rtl/buddy_allocator.sv =====
// Buddy allocator top level: request sequencer over the mark and owner memories.
//
//   channel   ports                 direction   accepted when
//   request   start, busy, req      in          start && !busy
//   result    done, rsp             out         done (one cycle, no stall)
//
// Bad size, unknown process and held block finish in the check step, memory full
// in the search step. An allocate runs check, search, find and take, then a split
// read and write per split level; a free runs check and a merge read and write per
// merge level. Each mark access is a read, then a write of the same word, on the
// single port of the mark memory. Reset leaves only the whole memory free and no
// process owning a block; no clearing pass is needed. The result strobe is seen
// in the cycle after the last step, and a new request may be taken in that cycle.
`default_nettype none

module buddy_allocator import bal_pkg::*; #(
	parameter int TOP_ORDER = 10,
	parameter int PROCESSES = 256
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	output logic          busy,
	input  wire bal_req_t req,
	output logic          done,
	output bal_rsp_t      rsp
);

	localparam int NW  = order_wbase(TOP_ORDER, TOP_ORDER + 1);
	localparam int WAW = $clog2(NW + 1);
	localparam int MAW = $clog2(NW);
	localparam int OW  = $clog2(TOP_ORDER + 1);
	localparam int IXW = (TOP_ORDER > WORD_LW) ? TOP_ORDER : WORD_LW;
	localparam int PW  = $clog2(PROCESSES);

	typedef enum logic [9:0] {
		S_IDLE     = 10'b0000000001,
		S_CHECK    = 10'b0000000010,
		S_SRCH     = 10'b0000000100,
		S_FIND     = 10'b0000001000,
		S_TAKE     = 10'b0000010000,
		S_SPLIT_RD = 10'b0000100000,
		S_SPLIT_WR = 10'b0001000000,
		S_MERGE_RD = 10'b0010000000,
		S_MERGE_WR = 10'b0100000000,
		S_SPARE    = 10'b1000000000
	} state_t;

	state_t            state_q;
	bal_req_t          req_q;
	logic [OW-1:0]     k_q;
	logic [OW-1:0]     j_q;
	logic [OW-1:0]     ok_q;
	logic [IXW-1:0]    idx_q;
	logic [IXW-1:0]    start_q;
	logic [MAW-1:0]    w_q;
	logic [WORD_LW-1:0] bit_q;
	logic              done_q;
	bal_rsp_t          rsp_q;

	// Memory interface signals.
	logic              m_rd, m_wr;
	logic [MAW-1:0]    m_addr;
	logic [WORD_W-1:0] m_wdata, m_rdata;
	logic [NW-1:0]     flags;
	logic [PW-1:0]     pidx;
	logic              o_valid, o_rd, o_wr, o_clr;
	logic [IXW-1:0]    o_start, o_wstart;
	logic [OW-1:0]     o_order;

	bal_marks #(.NW(NW), .MAW(MAW)) u_marks (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (m_rd),
		.wr_en  (m_wr),
		.addr   (m_addr),
		.wdata  (m_wdata),
		.rdata  (m_rdata),
		.flags  (flags)
	);

	bal_owner #(.PROCESSES(PROCESSES), .PW(PW), .IXW(IXW), .OW(OW)) u_owner (
		.clk      (clk),
		.arst_n   (arst_n),
		.vidx     (pidx),
		.valid    (o_valid),
		.rd_en    (o_rd),
		.rd_idx   (PW'(req.process_id)),
		.rd_start (o_start),
		.rd_order (o_order),
		.wr_en    (o_wr),
		.wr_idx   (pidx),
		.wr_start (o_wstart),
		.wr_order (k_q),
		.clr_en   (o_clr)
	);

	assign pidx = PW'(req_q.process_id);

	// Word layout per order, and whether each order holds a free block.
	logic [WAW-1:0]   base_tab [TOP_ORDER+2];
	logic [TOP_ORDER:0] has_free;

	for (genvar g = 0; g <= TOP_ORDER + 1; g++) begin : g_base
		assign base_tab[g] = WAW'(order_wbase(TOP_ORDER, g));
	end

	for (genvar g = 0; g <= TOP_ORDER; g++) begin : g_has
		assign has_free[g] = |flags[order_wbase(TOP_ORDER, g + 1) - 1 :
			order_wbase(TOP_ORDER, g)];
	end

	// Size checks and rounding to an order.
	logic              bad_size;
	logic [OW-1:0]     k_calc;
	logic [SIZE_W-1:0] size_m1;

	assign size_m1  = req_q.request_size - SIZE_W'(1);
	assign bad_size = (req_q.request_size == '0) ||
		({1'b0, req_q.request_size} > ((SIZE_W + 1)'(1) << TOP_ORDER));

	always_comb begin
		k_calc = '0;
		for (int m = TOP_ORDER; m >= 0; m--) begin
			if ((32'(size_m1) >> m) == 0) begin
				k_calc = OW'(m);
			end
		end
	end

	// Nearest order at or above the request that has a free block.
	logic          j_found;
	logic [OW-1:0] j_sel;

	always_comb begin
		j_found = 1'b0;
		j_sel   = '0;
		for (int m = TOP_ORDER; m >= 0; m--) begin
			if (has_free[m] && (OW'(m) >= k_q)) begin
				j_found = 1'b1;
				j_sel   = OW'(m);
			end
		end
	end

	// Lowest word with a free mark inside the chosen order.
	logic [MAW-1:0] w_sel;

	always_comb begin
		w_sel = '0;
		for (int w = NW - 1; w >= 0; w--) begin
			if (flags[w] && (WAW'(w) >= base_tab[j_q]) && (WAW'(w) < base_tab[j_q + OW'(1)]))
			begin
				w_sel = MAW'(w);
			end
		end
	end

	// Lowest free bit in the word just read.
	logic [WORD_LW-1:0] b_sel;

	always_comb begin
		b_sel = '0;
		for (int b = WORD_W - 1; b >= 0; b--) begin
			if (m_rdata[b]) begin
				b_sel = WORD_LW'(b);
			end
		end
	end

	// Word address of a mark.
	function automatic logic [MAW-1:0] mark_addr(logic [WAW-1:0] base, logic [IXW-1:0] i);
		return MAW'(base + WAW'(i >> WORD_LW));
	endfunction

	logic [IXW-1:0] take_idx, split_idx, buddy_idx;
	logic           buddy_free, at_top;

	assign take_idx   = IXW'((32'(w_q) - 32'(base_tab[j_q])) << WORD_LW) | IXW'(b_sel);
	assign split_idx  = {idx_q[IXW-2:0], 1'b1};
	assign buddy_idx  = idx_q ^ IXW'(1);
	assign at_top     = (k_q == OW'(TOP_ORDER));
	assign buddy_free = m_rdata[buddy_idx[WORD_LW-1:0]];

	// Sequencer.
	always_comb begin
		m_rd     = 1'b0;
		m_wr     = 1'b0;
		m_addr   = w_q;
		m_wdata  = m_rdata;
		o_rd     = 1'b0;
		o_wr     = 1'b0;
		o_clr    = 1'b0;
		o_wstart = IXW'(idx_q << k_q);
		case (state_q)
			S_IDLE: begin
				o_rd = start;
			end
			S_FIND: begin
				m_rd   = 1'b1;
				m_addr = w_sel;
			end
			S_TAKE: begin
				m_wr    = 1'b1;
				m_wdata = m_rdata & ~(WORD_W'(1) << b_sel);
				o_wr    = (j_q == k_q);
				o_wstart = IXW'(take_idx << k_q);
			end
			S_SPLIT_RD: begin
				m_rd   = 1'b1;
				m_addr = mark_addr(base_tab[j_q - OW'(1)], split_idx);
			end
			S_SPLIT_WR: begin
				m_wr    = 1'b1;
				m_wdata = m_rdata | (WORD_W'(1) << bit_q);
				o_wr    = (j_q == k_q);
			end
			S_MERGE_RD: begin
				m_rd   = 1'b1;
				m_addr = mark_addr(base_tab[k_q], idx_q);
			end
			S_MERGE_WR: begin
				m_wr = 1'b1;
				if (!at_top && buddy_free) begin
					m_wdata = m_rdata & ~(WORD_W'(1) << buddy_idx[WORD_LW-1:0]);
				end else begin
					m_wdata = m_rdata | (WORD_W'(1) << idx_q[WORD_LW-1:0]);
					o_clr   = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Result of a finished transaction.
	function automatic bal_rsp_t make_rsp(bal_status_t st, logic [7:0] pid,
		logic [IXW-1:0] s, logic [OW-1:0] k);
		bal_rsp_t r;
		r.status          = st;
		r.echo_process_id = pid;
		r.start_address   = ADDR_W'(s);
		r.end_address     = ADDR_W'(32'(s) + (32'(1) << k) - 32'd1);
		return r;
	endfunction

	function automatic bal_rsp_t err_rsp(bal_status_t st, logic [7:0] pid);
		bal_rsp_t r;
		r.status          = st;
		r.echo_process_id = pid;
		r.start_address   = '0;
		r.end_address     = '0;
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						req_q   <= req;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (32'(req_q.process_id) >= PROCESSES) begin
						rsp_q   <= err_rsp(ST_UNKNOWN, req_q.process_id);
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else if (req_q.op == OP_ALLOC) begin
						if (bad_size) begin
							rsp_q   <= err_rsp(ST_BAD_SIZE, req_q.process_id);
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else if (o_valid) begin
							rsp_q   <= err_rsp(ST_HELD, req_q.process_id);
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							k_q     <= k_calc;
							state_q <= S_SRCH;
						end
					end else if (!o_valid) begin
						rsp_q   <= err_rsp(ST_UNKNOWN, req_q.process_id);
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						k_q     <= o_order;
						ok_q    <= o_order;
						start_q <= o_start;
						idx_q   <= o_start >> o_order;
						state_q <= S_MERGE_RD;
					end
				end
				S_SRCH: begin
					if (!j_found) begin
						rsp_q   <= err_rsp(ST_FULL, req_q.process_id);
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						j_q     <= j_sel;
						state_q <= S_FIND;
					end
				end
				S_FIND: begin
					w_q     <= w_sel;
					state_q <= S_TAKE;
				end
				S_TAKE: begin
					idx_q <= take_idx;
					if (j_q == k_q) begin
						rsp_q   <= make_rsp(ST_ALLOCATED, req_q.process_id,
							IXW'(take_idx << k_q), k_q);
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_SPLIT_RD;
					end
				end
				S_SPLIT_RD: begin
					w_q     <= m_addr;
					bit_q   <= split_idx[WORD_LW-1:0];
					j_q     <= j_q - OW'(1);
					idx_q   <= {idx_q[IXW-2:0], 1'b0};
					state_q <= S_SPLIT_WR;
				end
				S_SPLIT_WR: begin
					if (j_q == k_q) begin
						rsp_q   <= make_rsp(ST_ALLOCATED, req_q.process_id,
							IXW'(idx_q << k_q), k_q);
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_SPLIT_RD;
					end
				end
				S_MERGE_RD: begin
					w_q     <= m_addr;
					state_q <= S_MERGE_WR;
				end
				S_MERGE_WR: begin
					if (!at_top && buddy_free) begin
						idx_q   <= idx_q >> 1;
						k_q     <= k_q + OW'(1);
						state_q <= S_MERGE_RD;
					end else begin
						rsp_q   <= make_rsp(ST_FREED, req_q.process_id, start_q, ok_q);
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

`default_nettype wire
